>>> sv/ictas_pkg.sv
package ictas_pkg;

    localparam logic [1:0] OP_NODE  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef logic [3:0] t_cmd;

    localparam t_cmd CMD_NOP     = 4'd0;
    localparam t_cmd CMD_WR_NODE = 4'd1;
    localparam t_cmd CMD_WR_PT   = 4'd2;
    localparam t_cmd CMD_LATCH   = 4'd3;
    localparam t_cmd CMD_LO      = 4'd4;
    localparam t_cmd CMD_HI      = 4'd5;
    localparam t_cmd CMD_NSCAN   = 4'd6;
    localparam t_cmd CMD_NI      = 4'd7;
    localparam t_cmd CMD_NI1     = 4'd8;
    localparam t_cmd CMD_ROWST   = 4'd9;
    localparam t_cmd CMD_LAST    = 4'd10;
    localparam t_cmd CMD_PSCAN   = 4'd11;
    localparam t_cmd CMD_PM1     = 4'd12;
    localparam t_cmd CMD_PM2     = 4'd13;
    localparam t_cmd CMD_LGO     = 4'd14;
    localparam t_cmd CMD_LDONE   = 4'd15;

    typedef struct packed {
        logic n_gt2;
        logic nscan_last;
        logic len_zero;
        logic len_one;
        logic pscan_last;
        logic rs;
        logic nonzero;
        logic lerp_done;
    } t_stat;

endpackage

>>> sv/inverse_cdf_angle_table_sampler.sv
// channel   direction  handshake                      payload
// command   in         start high, busy low           i_op i_row i_column i_*_value i_point_count
// result    out        o_strobe, one cycle, no stall  o_angle o_energy_clamped o_prob_clamped
// config    in         i_cfg_valid && o_cfg_ready     i_cfg_data (energy rows in use)
//
// writes of nodes and points leave busy low
// a query's run time is set by the linear node and point scans and up to 3 lerps, each
// run through the one-bit-a-cycle divider in the lerp unit
// reset clears the controller and sets rows in use to 2; table memories hold
// whatever they had until written; the result side cannot stall
module inverse_cdf_angle_table_sampler #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_row,
    input  logic [6:0]  i_column,
    input  logic [27:0] i_energy_value,
    input  logic [24:0] i_prob_value,
    input  logic [23:0] i_angle_value,
    input  logic [7:0]  i_point_count,
    output logic        o_strobe,
    output logic [23:0] o_angle,
    output logic        o_energy_clamped,
    output logic        o_prob_clamped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    logic [6:0]       r_rows_in_use;
    ictas_pkg::t_cmd  cmd;
    ictas_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= 7'd2;
        end else if (i_cfg_valid) begin
            r_rows_in_use <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    ictas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    ictas_dp #(
        .MAX_NODES  (MAX_NODES),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rows_cfg       (r_rows_in_use),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_energy_value   (i_energy_value),
        .i_prob_value     (i_prob_value),
        .i_angle_value    (i_angle_value),
        .i_point_count    (i_point_count),
        .o_stat           (stat),
        .o_angle          (o_angle),
        .o_energy_clamped (o_energy_clamped),
        .o_prob_clamped   (o_prob_clamped)
    );

endmodule

>>> sv/ictas_lerp.sv
module ictas_lerp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [27:0] i_x1,
    input  logic [27:0] i_x2,
    input  logic [27:0] i_x,
    input  logic [23:0] i_y1,
    input  logic [23:0] i_y2,
    output logic        o_done,
    output logic [23:0] o_y
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [23:0] r_y, n_y;
    logic [23:0] r_y1, n_y1;
    logic        r_up, n_up;
    logic [27:0] r_w, n_w;
    logic [27:0] r_d, n_d;
    logic [23:0] r_dy, n_dy;
    logic [53:0] r_num, n_num;
    logic [28:0] r_den, n_den;
    logic [28:0] r_rem, n_rem;
    logic [23:0] r_q, n_q;

    logic [27:0] xc;
    logic [29:0] rem_sh;
    logic [29:0] rem_sub;
    logic        qbit;
    logic [23:0] q_new;
    logic [51:0] prod;

    always_comb begin
        xc = i_x;
        if (i_x < i_x1) xc = i_x1;
        if (i_x > i_x2) xc = i_x2;
        rem_sh  = {r_rem, r_num[53]};
        rem_sub = rem_sh - {1'b0, r_den};
        qbit    = (rem_sh >= {1'b0, r_den});
        q_new   = {r_q[22:0], qbit};
        prod    = 52'(r_dy) * 52'(r_d);

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_y     = r_y;
        n_y1    = r_y1;
        n_up    = r_up;
        n_w     = r_w;
        n_d     = r_d;
        n_dy    = r_dy;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_q     = r_q;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    if (i_x2 <= i_x1) begin
                        n_y    = i_y1;
                        n_done = 1'b1;
                    end else begin
                        n_y1    = i_y1;
                        n_up    = (i_y2 >= i_y1);
                        n_dy    = (i_y2 >= i_y1) ? (i_y2 - i_y1) : (i_y1 - i_y2);
                        n_w     = i_x2 - i_x1;
                        n_d     = xc - i_x1;
                        n_phase = PH_MUL;
                    end
                end
            end
            PH_MUL: begin
                // rounded quotient: (2*dy*d + w) / (2*w)
                n_num   = {1'b0, prod, 1'b0} + {26'd0, r_w};
                n_den   = {r_w, 1'b0};
                n_rem   = '0;
                n_q     = '0;
                n_cnt   = 6'd53;
                n_phase = PH_DIV;
            end
            PH_DIV: begin
                n_rem = qbit ? rem_sub[28:0] : rem_sh[28:0];
                n_q   = q_new;
                n_num = {r_num[52:0], 1'b0};
                if (r_cnt == 6'd0) begin
                    n_y     = r_up ? (r_y1 + q_new) : (r_y1 - q_new);
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_y   <= n_y;
        r_y1  <= n_y1;
        r_up  <= n_up;
        r_w   <= n_w;
        r_d   <= n_d;
        r_dy  <= n_dy;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

>>> sv/ictas_dp.sv
module ictas_dp #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_POINTS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ictas_pkg::t_cmd   i_cmd,
    input  logic [6:0]        i_rows_cfg,
    input  logic [5:0]        i_row,
    input  logic [6:0]        i_column,
    input  logic [27:0]       i_energy_value,
    input  logic [24:0]       i_prob_value,
    input  logic [23:0]       i_angle_value,
    input  logic [7:0]        i_point_count,
    output ictas_pkg::t_stat  o_stat,
    output logic [23:0]       o_angle,
    output logic              o_energy_clamped,
    output logic              o_prob_clamped
);
    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = MAX_NODES * MAX_POINTS;
    localparam int AW = $clog2(DEPTH);

    logic [27:0] node_mem [MAX_NODES];
    logic [7:0]  rl_mem   [MAX_NODES];
    logic [24:0] prob_mem [DEPTH];
    logic [23:0] ang_mem  [DEPTH];

    logic [27:0] r_node_q;
    logic [7:0]  r_rl_q;
    logic [24:0] r_prob_q;
    logic [23:0] r_ang_q;

    logic [27:0] r_e, n_e;
    logic [24:0] r_p, n_p;
    logic [CW-1:0] r_n, n_n;
    logic [27:0] r_elo, n_elo;
    logic [NW-1:0] r_i, n_i;
    logic [NW-1:0] r_j, n_j;
    logic [NW-1:0] r_node_addr, n_node_addr;
    logic [27:0] r_x1, n_x1;
    logic [27:0] r_x2, n_x2;
    logic [LW-1:0] r_len0, n_len0;
    logic [LW-1:0] r_len1, n_len1;
    logic        r_rs, n_rs;
    logic [24:0] r_pr, n_pr;
    logic [PW-1:0] r_m, n_m;
    logic [PW-1:0] r_k, n_k;
    logic [AW-1:0] r_pt_addr, n_pt_addr;
    logic [24:0] r_y1p, n_y1p;
    logic [24:0] r_y2p, n_y2p;
    logic [23:0] r_y1a, n_y1a;
    logic [23:0] r_y2a, n_y2a;
    logic [23:0] r_v0, n_v0;
    logic [23:0] r_v1, n_v1;
    logic        r_nz, n_nz;
    logic        r_ec, n_ec;
    logic        r_pc, n_pc;
    logic [23:0] r_ang, n_ang;
    logic        r_e_phase, n_e_phase;

    logic [NW-1:0] rr;
    logic [LW-1:0] len_cur;
    logic [AW-1:0] base;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] n_eff;
    logic [LW-1:0] len_clip;
    logic          hit_node;
    logic          hit_pt;
    logic [NW-1:0] i_new;
    logic [PW-1:0] m_new;
    logic          row_ok;
    logic          col_ok;
    logic          l_start;
    logic [27:0]   l_x1, l_x2, l_x;
    logic [23:0]   l_y1, l_y2;
    logic          l_done;
    logic [23:0]   l_y;

    always_comb begin
        rr      = r_i + NW'(r_rs);
        len_cur = r_rs ? r_len1 : r_len0;
        base    = AW'(AW'(rr) * AW'(MAX_POINTS));
        wr_addr = AW'(AW'(i_row) * AW'(MAX_POINTS)) + AW'(i_column);
        row_ok  = (32'(i_row) < MAX_NODES);
        col_ok  = (32'(i_column) < MAX_POINTS);
        if (i_rows_cfg < 7'd2) n_eff = CW'(2);
        else if (32'(i_rows_cfg) > MAX_NODES) n_eff = CW'(MAX_NODES);
        else n_eff = CW'(i_rows_cfg);
        if (32'(r_rl_q) > MAX_POINTS) len_clip = LW'(MAX_POINTS);
        else len_clip = LW'(r_rl_q);
        hit_node = (r_node_q <= r_e);
        i_new    = hit_node ? r_j : r_i;
        hit_pt   = (r_prob_q <= r_pr);
        m_new    = hit_pt ? r_k : r_m;
    end

    // one lerp unit shared by both rows and the energy step
    always_comb begin
        l_start = (i_cmd == ictas_pkg::CMD_LGO);
        l_x1 = {3'd0, r_y1p};
        l_x2 = {3'd0, r_y2p};
        l_x  = {3'd0, r_pr};
        l_y1 = r_y1a;
        l_y2 = r_y2a;
        if (r_e_phase) begin
            l_x1 = r_x1;
            l_x2 = r_x2;
            l_x  = r_e;
            l_y1 = r_v0;
            l_y2 = r_v1;
        end
    end

    ictas_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (l_start),
        .i_x1    (l_x1),
        .i_x2    (l_x2),
        .i_x     (l_x),
        .i_y1    (l_y1),
        .i_y2    (l_y2),
        .o_done  (l_done),
        .o_y     (l_y)
    );

    always_comb begin
        n_e = r_e;  n_p = r_p;  n_n = r_n;  n_elo = r_elo;
        n_i = r_i;  n_j = r_j;  n_node_addr = r_node_addr;
        n_x1 = r_x1;  n_x2 = r_x2;  n_len0 = r_len0;  n_len1 = r_len1;
        n_rs = r_rs;  n_pr = r_pr;  n_m = r_m;  n_k = r_k;  n_pt_addr = r_pt_addr;
        n_y1p = r_y1p;  n_y2p = r_y2p;  n_y1a = r_y1a;  n_y2a = r_y2a;
        n_v0 = r_v0;  n_v1 = r_v1;  n_nz = r_nz;  n_ec = r_ec;  n_pc = r_pc;
        n_ang = r_ang;  n_e_phase = r_e_phase;
        case (i_cmd)
            ictas_pkg::CMD_LATCH: begin
                n_e = i_energy_value;
                n_p = i_prob_value;
                n_n = n_eff;
                n_node_addr = '0;
                n_ec = 1'b0;
                n_pc = 1'b0;
                n_nz = 1'b0;
                n_e_phase = 1'b0;
            end
            ictas_pkg::CMD_LO: begin
                n_elo = r_node_q;
                n_node_addr = NW'(r_n - CW'(1));
            end
            ictas_pkg::CMD_HI: begin
                if (r_e < r_elo) begin
                    n_e  = r_elo;
                    n_ec = 1'b1;
                end else if (r_e > r_node_q) begin
                    n_e  = r_node_q;
                    n_ec = 1'b1;
                end
                n_i = '0;
                n_j = NW'(1);
                n_node_addr = o_stat.n_gt2 ? NW'(1) : '0;
            end
            ictas_pkg::CMD_NSCAN: begin
                n_i = i_new;
                if (o_stat.nscan_last) begin
                    n_node_addr = i_new;
                end else begin
                    n_j = r_j + NW'(1);
                    n_node_addr = r_j + NW'(1);
                end
            end
            ictas_pkg::CMD_NI: begin
                n_x1 = r_node_q;
                n_len0 = len_clip;
                n_node_addr = r_i + NW'(1);
            end
            ictas_pkg::CMD_NI1: begin
                n_x2 = r_node_q;
                n_len1 = len_clip;
                n_rs = 1'b0;
            end
            ictas_pkg::CMD_ROWST: begin
                if (len_cur == '0) begin
                    // empty row: only the implicit origin point
                    if (r_p != '0) n_pc = 1'b1;
                    if (r_rs) n_v1 = '0;
                    else n_v0 = '0;
                    n_rs = 1'b1;
                end else begin
                    n_pt_addr = base + AW'(len_cur - LW'(1));
                end
            end
            ictas_pkg::CMD_LAST: begin
                if (r_p > r_prob_q) begin
                    n_pr = r_prob_q;
                    n_pc = 1'b1;
                end else begin
                    n_pr = r_p;
                end
                n_m = '0;
                n_k = PW'(1);
                n_pt_addr = base;
            end
            ictas_pkg::CMD_PSCAN: begin
                n_m = m_new;
                if (o_stat.pscan_last) begin
                    n_pt_addr = base + AW'(m_new) - AW'(1);
                end else begin
                    n_k = r_k + PW'(1);
                    n_pt_addr = base + AW'(r_k);
                end
            end
            ictas_pkg::CMD_PM1: begin
                n_y1p = (r_m == '0) ? '0 : r_prob_q;
                n_y1a = (r_m == '0) ? '0 : r_ang_q;
                n_pt_addr = base + AW'(r_m);
            end
            ictas_pkg::CMD_PM2: begin
                n_y2p = r_prob_q;
                n_y2a = r_ang_q;
                if (r_y1a != '0 || r_ang_q != '0) n_nz = 1'b1;
            end
            ictas_pkg::CMD_LDONE: begin
                if (r_e_phase) begin
                    n_ang = l_y;
                end else begin
                    if (r_rs) n_v1 = l_y;
                    else n_v0 = l_y;
                    if (r_rs) begin
                        // both rows done: next lerp is across energy, or zero
                        n_e_phase = 1'b1;
                        if (!r_nz) n_ang = '0;
                    end
                    n_rs = 1'b1;
                end
            end
            default: ;
        endcase
        if (i_cmd == ictas_pkg::CMD_ROWST && len_cur == '0 && r_rs) begin
            n_e_phase = 1'b1;
            if (!r_nz) n_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == ictas_pkg::CMD_WR_NODE && row_ok) begin
            node_mem[NW'(i_row)] <= i_energy_value;
            rl_mem[NW'(i_row)]   <= i_point_count;
        end
        r_node_q <= node_mem[n_node_addr];
        r_rl_q   <= rl_mem[n_node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == ictas_pkg::CMD_WR_PT && row_ok && col_ok) begin
            prob_mem[wr_addr] <= i_prob_value;
            ang_mem[wr_addr]  <= i_angle_value;
        end
        r_prob_q <= prob_mem[n_pt_addr];
        r_ang_q  <= ang_mem[n_pt_addr];
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;  r_p <= n_p;  r_n <= n_n;  r_elo <= n_elo;
        r_i <= n_i;  r_j <= n_j;  r_node_addr <= n_node_addr;
        r_x1 <= n_x1;  r_x2 <= n_x2;  r_len0 <= n_len0;  r_len1 <= n_len1;
        r_rs <= n_rs;  r_pr <= n_pr;  r_m <= n_m;  r_k <= n_k;  r_pt_addr <= n_pt_addr;
        r_y1p <= n_y1p;  r_y2p <= n_y2p;  r_y1a <= n_y1a;  r_y2a <= n_y2a;
        r_v0 <= n_v0;  r_v1 <= n_v1;  r_nz <= n_nz;  r_ec <= n_ec;  r_pc <= n_pc;
        r_ang <= n_ang;  r_e_phase <= n_e_phase;
    end

    always_comb begin
        o_stat.n_gt2      = (r_n > CW'(2));
        o_stat.nscan_last = (CW'(r_j) == r_n - CW'(2));
        o_stat.len_zero   = (len_cur == '0);
        o_stat.len_one    = (len_cur == LW'(1));
        o_stat.pscan_last = (LW'(r_k) == len_cur - LW'(1));
        o_stat.rs         = r_rs;
        o_stat.nonzero    = r_nz;
        o_stat.lerp_done  = l_done;
    end

    assign o_angle          = r_ang;
    assign o_energy_clamped = r_ec;
    assign o_prob_clamped   = r_pc;

endmodule

>>> sv/ictas_ctrl.sv
module ictas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  ictas_pkg::t_stat  i_stat,
    output ictas_pkg::t_cmd   o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LO    = 5'd1;
    localparam logic [4:0] S_HI    = 5'd2;
    localparam logic [4:0] S_NSCAN = 5'd3;
    localparam logic [4:0] S_NI    = 5'd4;
    localparam logic [4:0] S_NI1   = 5'd5;
    localparam logic [4:0] S_ROW   = 5'd6;
    localparam logic [4:0] S_LAST  = 5'd7;
    localparam logic [4:0] S_PSCAN = 5'd8;
    localparam logic [4:0] S_PM1   = 5'd9;
    localparam logic [4:0] S_PM2   = 5'd10;
    localparam logic [4:0] S_RL    = 5'd11;
    localparam logic [4:0] S_RW    = 5'd12;
    localparam logic [4:0] S_EL    = 5'd13;
    localparam logic [4:0] S_EW    = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = ictas_pkg::CMD_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == ictas_pkg::OP_QUERY) begin
                        o_cmd   = ictas_pkg::CMD_LATCH;
                        n_state = S_LO;
                    end else if (i_op == ictas_pkg::OP_NODE) begin
                        o_cmd = ictas_pkg::CMD_WR_NODE;
                    end else if (i_op == ictas_pkg::OP_POINT) begin
                        o_cmd = ictas_pkg::CMD_WR_PT;
                    end
                end
            end
            S_LO: begin
                o_cmd   = ictas_pkg::CMD_LO;
                n_state = S_HI;
            end
            S_HI: begin
                o_cmd   = ictas_pkg::CMD_HI;
                n_state = i_stat.n_gt2 ? S_NSCAN : S_NI;
            end
            S_NSCAN: begin
                o_cmd   = ictas_pkg::CMD_NSCAN;
                n_state = i_stat.nscan_last ? S_NI : S_NSCAN;
            end
            S_NI: begin
                o_cmd   = ictas_pkg::CMD_NI;
                n_state = S_NI1;
            end
            S_NI1: begin
                o_cmd   = ictas_pkg::CMD_NI1;
                n_state = S_ROW;
            end
            S_ROW: begin
                o_cmd = ictas_pkg::CMD_ROWST;
                if (i_stat.len_zero) n_state = i_stat.rs ? S_EL : S_ROW;
                else n_state = S_LAST;
            end
            S_LAST: begin
                o_cmd   = ictas_pkg::CMD_LAST;
                n_state = i_stat.len_one ? S_PM1 : S_PSCAN;
            end
            S_PSCAN: begin
                o_cmd   = ictas_pkg::CMD_PSCAN;
                n_state = i_stat.pscan_last ? S_PM1 : S_PSCAN;
            end
            S_PM1: begin
                o_cmd   = ictas_pkg::CMD_PM1;
                n_state = S_PM2;
            end
            S_PM2: begin
                o_cmd   = ictas_pkg::CMD_PM2;
                n_state = S_RL;
            end
            S_RL: begin
                o_cmd   = ictas_pkg::CMD_LGO;
                n_state = S_RW;
            end
            S_RW: begin
                if (i_stat.lerp_done) begin
                    o_cmd   = ictas_pkg::CMD_LDONE;
                    n_state = i_stat.rs ? S_EL : S_ROW;
                end
            end
            S_EL: begin
                // all four corner angles zero: result already cleared
                if (i_stat.nonzero) begin
                    o_cmd   = ictas_pkg::CMD_LGO;
                    n_state = S_EW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_EW: begin
                if (i_stat.lerp_done) begin
                    o_cmd   = ictas_pkg::CMD_LDONE;
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe longer than one cycle");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op == ictas_pkg::OP_QUERY) |=> o_busy)
        else $error("query not taken");
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op != ictas_pkg::OP_QUERY) |=> (!o_busy && !o_strobe))
        else $error("write caused activity");

endmodule
